>>> sv/tick_time_scale_converter_macros.svh
// Assertion macros shared by the converter RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef TICK_TIME_SCALE_CONVERTER_MACROS_SVH
`define TICK_TIME_SCALE_CONVERTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside reset.
`define TTSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition implies another in the same cycle.
`define TTSC_ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |-> (post)) else $error(msg);

`else

`define TTSC_ASSERT(label, prop, msg)
`define TTSC_ASSERT_IMPLY(label, pre, post, msg)

`endif

`endif

>>> sv/ttsc_pkg.sv
package ttsc_pkg;

    // Field widths
    localparam int RATE_W  = 32;
    localparam int VALUE_W = 63;
    localparam int CONV_W  = 64;
    localparam int HALF_W  = 32;
    localparam int TOP_W   = VALUE_W - HALF_W;
    localparam int PT_W    = TOP_W + RATE_W;

    // Scaling constants
    localparam logic [RATE_W-1:0] NS_PER_SECOND = 32'd1000000000;
    localparam logic [RATE_W-1:0] RATE_RESET    = 32'd1000000000;

    // Control that moves an item along a pipeline
    typedef struct packed {
        logic adv;
        logic vld;
    } t_stage_ctl;

endpackage

>>> sv/ttsc_div.sv
module ttsc_div #(
    parameter int DW = 64,
    parameter int SW = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ttsc_pkg::t_stage_ctl         i_ctl,
    input  logic [DW-1:0]                i_dividend,
    input  logic [ttsc_pkg::RATE_W-1:0]  i_divisor,
    input  logic [SW-1:0]                i_side,
    output logic                         o_valid,
    output logic [DW-1:0]                o_quot,
    output logic [ttsc_pkg::RATE_W-1:0]  o_rem,
    output logic [ttsc_pkg::RATE_W-1:0]  o_divisor,
    output logic [SW-1:0]                o_side
);
    import ttsc_pkg::*;

    // One quotient bit per stage; dq holds remaining dividend bits on top
    // and finished quotient bits at the bottom.
    logic              r_vld  [DW];
    logic [DW-1:0]     r_dq   [DW];
    logic [RATE_W-1:0] r_rem  [DW];
    logic [RATE_W-1:0] r_den  [DW];
    logic [SW-1:0]     r_side [DW];

    for (genvar s = 0; s < DW; s++) begin : g_stage
        logic              s_vld;
        logic [DW-1:0]     s_dq;
        logic [RATE_W-1:0] s_rem;
        logic [RATE_W-1:0] s_den;
        logic [SW-1:0]     s_side;
        logic [RATE_W:0]   s_trial;
        logic [RATE_W:0]   s_diff;
        logic              s_fit;
        logic [DW-1:0]     n_dq;
        logic [RATE_W-1:0] n_rem;

        // Pick the stage source: the ports or the stage before
        if (s == 0) begin : g_first
            assign s_vld  = i_ctl.vld;
            assign s_dq   = i_dividend;
            assign s_rem  = '0;
            assign s_den  = i_divisor;
            assign s_side = i_side;
        end else begin : g_next
            assign s_vld  = r_vld[s-1];
            assign s_dq   = r_dq[s-1];
            assign s_rem  = r_rem[s-1];
            assign s_den  = r_den[s-1];
            assign s_side = r_side[s-1];
        end

        // Shift in the next dividend bit and try to subtract the divisor
        assign s_trial = {s_rem, s_dq[DW-1]};
        assign s_diff  = s_trial - {1'b0, s_den};
        assign s_fit   = s_trial >= {1'b0, s_den};
        assign n_dq    = {s_dq[DW-2:0], s_fit};
        assign n_rem   = s_fit ? s_diff[RATE_W-1:0] : s_trial[RATE_W-1:0];

        // Advance the stage when the pipeline moves
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_ctl.adv) begin
                r_vld[s] <= s_vld;
            end
            if (i_ctl.adv) begin
                r_dq[s]   <= n_dq;
                r_rem[s]  <= n_rem;
                r_den[s]  <= s_den;
                r_side[s] <= s_side;
            end
        end
    end

    assign o_valid   = r_vld[DW-1];
    assign o_quot    = r_dq[DW-1];
    assign o_rem     = r_rem[DW-1];
    assign o_divisor = r_den[DW-1];
    assign o_side    = r_side[DW-1];

endmodule

>>> sv/tick_time_scale_converter.sv
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_ready   i_value[62:0], i_direction
// out       output     o_out_valid / i_out_ready o_converted[63:0]
// cfg       input      i_cfg_we                  i_cfg_data[31:0] (tick rate)
//
// One item enters per cycle while the output register can move; the pipeline has
// one multiply stage, 63 divider stages on the high product, one add stage,
// 64 divider stages on the low dividend and one output stage.
// Synchronous active-low reset clears all valid bits and loads the tick
// rate with one billion.
// A stall on the output freezes the whole pipeline, so no item is lost or
// repeated; the input is ready whenever the output register can move.
`include "tick_time_scale_converter_macros.svh"

module tick_time_scale_converter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [ttsc_pkg::VALUE_W-1:0]      i_value,
    input  logic                              i_direction,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ttsc_pkg::CONV_W-1:0]       o_converted,
    input  logic                              i_cfg_we,
    input  logic [ttsc_pkg::RATE_W-1:0]       i_cfg_data
);
    import ttsc_pkg::*;

    localparam int PB_W = 2 * HALF_W;

    logic [RATE_W-1:0] r_rate_hz;
    logic              s_adv;

    // Tick rate register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_hz <= RATE_RESET;
        end else if (i_cfg_we) begin
            r_rate_hz <= i_cfg_data;
        end
    end

    // Move the whole pipeline whenever the output register can take an item
    assign s_adv      = !o_out_valid || i_out_ready;
    assign o_in_ready = s_adv;

    // Multiply stage: pick scale factors, form both half products
    logic [RATE_W-1:0] s_rate;
    logic [RATE_W-1:0] s_num;
    logic [RATE_W-1:0] s_den;
    logic [TOP_W-1:0]  s_top;
    logic [HALF_W-1:0] s_bot;
    logic [PB_W-1:0]   s_pt_full;
    logic [PB_W-1:0]   s_pb_full;

    assign s_rate    = (r_rate_hz == '0) ? RATE_W'(1) : r_rate_hz;
    assign s_num     = i_direction ? s_rate : NS_PER_SECOND;
    assign s_den     = i_direction ? NS_PER_SECOND : s_rate;
    assign s_top     = i_value[VALUE_W-1:HALF_W];
    assign s_bot     = i_value[HALF_W-1:0];
    assign s_pt_full = PB_W'(s_top) * PB_W'(s_num);
    assign s_pb_full = PB_W'(s_bot) * PB_W'(s_num);

    logic              r_m_vld;
    logic [PT_W-1:0]   r_m_pt;
    logic [PB_W-1:0]   r_m_pb;
    logic [RATE_W-1:0] r_m_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (s_adv) begin
            r_m_vld <= i_in_valid;
        end
        if (s_adv) begin
            r_m_pt  <= s_pt_full[PT_W-1:0];
            r_m_pb  <= s_pb_full;
            r_m_den <= s_den;
        end
    end

    // Divide the high product; carry the low product alongside
    t_stage_ctl        s_div1_ctl;
    logic              s_q1_vld;
    logic [PT_W-1:0]   s_q1;
    logic [RATE_W-1:0] s_r1;
    logic [RATE_W-1:0] s_d1;
    logic [PB_W-1:0]   s_pb1;

    assign s_div1_ctl = '{adv: s_adv, vld: r_m_vld};

    ttsc_div #(
        .DW (PT_W),
        .SW (PB_W)
    ) u_div1 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (s_div1_ctl),
        .i_dividend (r_m_pt),
        .i_divisor  (r_m_den),
        .i_side     (r_m_pb),
        .o_valid    (s_q1_vld),
        .o_quot     (s_q1),
        .o_rem      (s_r1),
        .o_divisor  (s_d1),
        .o_side     (s_pb1)
    );

    // Add stage: fold the remainder into the low dividend, wrapping
    logic              r_s_vld;
    logic [PB_W-1:0]   r_s_sum;
    logic [RATE_W-1:0] r_s_den;
    logic [HALF_W-1:0] r_s_q1lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else if (s_adv) begin
            r_s_vld <= s_q1_vld;
        end
        if (s_adv) begin
            r_s_sum  <= s_pb1 + {s_r1, {HALF_W{1'b0}}};
            r_s_den  <= s_d1;
            r_s_q1lo <= s_q1[HALF_W-1:0];
        end
    end

    // Divide the low dividend; carry the high quotient alongside
    t_stage_ctl        s_div2_ctl;
    logic              s_q2_vld;
    logic [PB_W-1:0]   s_q2;
    logic [HALF_W-1:0] s_q1lo2;

    assign s_div2_ctl = '{adv: s_adv, vld: r_s_vld};

    ttsc_div #(
        .DW (PB_W),
        .SW (HALF_W)
    ) u_div2 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (s_div2_ctl),
        .i_dividend (r_s_sum),
        .i_divisor  (r_s_den),
        .i_side     (r_s_q1lo),
        .o_valid    (s_q2_vld),
        .o_quot     (s_q2),
        .o_rem      (),
        .o_divisor  (),
        .o_side     (s_q1lo2)
    );

    // Output stage: add the shifted high quotient, wrapping
    logic              r_out_vld;
    logic [CONV_W-1:0] r_out_conv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s_adv) begin
            r_out_vld <= s_q2_vld;
        end
        if (s_adv) begin
            r_out_conv <= s_q2 + {s_q1lo2, {HALF_W{1'b0}}};
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_converted = r_out_conv;

    // Checks on the arithmetic pipeline
    `TTSC_ASSERT_IMPLY(a_den_nonzero_mul, r_m_vld, r_m_den != '0, "zero divisor at multiply stage")
    `TTSC_ASSERT_IMPLY(a_den_nonzero_add, r_s_vld, r_s_den != '0, "zero divisor at add stage")
    `TTSC_ASSERT_IMPLY(a_rem_below_den, s_q1_vld, s_r1 < s_d1, "high remainder not below divisor")
    `TTSC_ASSERT_IMPLY(a_out_from_div, $rose(o_out_valid), $past(s_q2_vld), "result without divider item")

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import ttsc_pkg::*;

    // Direction codes
    localparam logic DIR_TICKS_TO_NS = 1'b0;
    localparam logic DIR_NS_TO_TICKS = 1'b1;

    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 150;
    localparam int PHASE_ITEMS  = 150;

    // Expected conversions, oldest first, with the converter's own view of the rate
    class conversion_tracker;
        logic [RATE_W-1:0] rate_hz;
        logic [CONV_W-1:0] pending_converted[$];
        int                fails;

        function new();
            rate_hz = RATE_RESET;
            fails   = 0;
        endfunction

        function void set_rate(logic [RATE_W-1:0] r);
            rate_hz = r;
        endfunction

        // Split into 32-bit halves, multiply, then divide; every step wraps at 64 bits
        function logic [63:0] mul_div(logic [63:0] v, logic [63:0] num, logic [63:0] den);
            logic [63:0] hi;
            logic [63:0] lo;
            logic [63:0] prod_hi;
            logic [63:0] part;
            hi  = v >> 32;
            lo  = v & 64'hffff_ffff;
            num = num & 64'hffff_ffff;
            den = den & 64'hffff_ffff;
            if (den == 64'd0) begin
                den = 64'd1;
            end
            prod_hi = hi * num;
            part    = (lo * num + ((prod_hi % den) << 32)) / den;
            return part + ((prod_hi / den) << 32);
        endfunction

        function void note_item(logic [VALUE_W-1:0] v, logic dir);
            logic [63:0] rate;
            logic [63:0] conv;
            // A zero rate behaves as one
            rate = (rate_hz == '0) ? 64'd1 : {32'd0, rate_hz};
            if (dir == DIR_TICKS_TO_NS) begin
                conv = mul_div({1'b0, v}, {32'd0, NS_PER_SECOND}, rate);
            end else begin
                conv = mul_div({1'b0, v}, rate, {32'd0, NS_PER_SECOND});
            end
            pending_converted.push_back(conv);
        endfunction

        function void check_converted(logic [CONV_W-1:0] got);
            logic [CONV_W-1:0] want;
            if (pending_converted.size() == 0) begin
                $error("converted: unexpected item, actual %0h", got);
                fails++;
                return;
            end
            want = pending_converted.pop_front();
            if (got !== want) begin
                $error("converted: expected %0h, actual %0h", want, got);
                fails++;
            end
        endfunction

        function int pending();
            return pending_converted.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [VALUE_W-1:0] i_value;
    logic               i_direction;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [CONV_W-1:0]  o_converted;
    logic               i_cfg_we;
    logic [RATE_W-1:0]  i_cfg_data;

    conversion_tracker board = new();
    bit                idle_on  = 1'b1;
    bit                hold_req = 1'b0;
    int                quiet_cycles;

    tick_time_scale_converter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_value     (i_value),
        .i_direction (i_direction),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_converted (o_converted),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock and known input levels from time zero
    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_value     = '0;
        i_direction = DIR_TICKS_TO_NS;
        i_out_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
    end

    always #1 i_clk = ~i_clk;

    // Pick a gap before the next item: mostly none, sometimes a random idle burst
    function automatic int idle_burst();
        if (idle_on && $urandom_range(0, 7) == 0) begin
            return $urandom_range(1, 17);
        end
        return 0;
    endfunction

    // Offer one item and hold it until accepted
    task automatic send_item(input logic [VALUE_W-1:0] v, input logic dir);
        int gap;
        gap = idle_burst();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_value     <= v;
        i_direction <= dir;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        board.note_item(v, dir);
    endtask

    // Drop valid and wait for every expected conversion to come out
    task automatic drain_all();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] r);
        drain_all();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= r;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        board.set_rate(r);
    endtask

    // Values that stress the halves: boundaries, tiny, huge and full random
    function automatic logic [VALUE_W-1:0] draw_value();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        unique case ($urandom_range(0, 7))
            0: return VALUE_W'(raw[19:0]);
            1: return 63'h0000_0000_ffff_ffff + VALUE_W'($urandom_range(0, 64))
                      - VALUE_W'(32);
            2: return {1'b1, 62'h0} | raw[62:0];
            3: return ~63'h0 - VALUE_W'($urandom_range(0, 255));
            4: return raw[62:0] >> $urandom_range(0, 62);
            default: return raw[62:0];
        endcase
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_item(draw_value(), 1'($urandom_range(0, 1)));
    endtask

    // Corner values in both directions
    task automatic send_corners();
        logic [VALUE_W-1:0] corners[4];
        corners = '{63'd0, 63'h0000_0000_ffff_ffff, 63'h0000_0001_0000_0000, ~63'd0};
        foreach (corners[k]) begin
            send_item(corners[k], DIR_TICKS_TO_NS);
            send_item(corners[k], DIR_NS_TO_TICKS);
        end
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && i_rst_n && $urandom_range(0, 9) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(0, 16)) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Compare every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_converted(o_converted);
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("[tick_time_scale_converter] ERROR");
            $finish;
        end
    end

    // Main sequence: reset, then one phase per tick rate
    initial begin
        logic [RATE_W-1:0] rate_list[8];
        rate_list = '{32'd1, 32'hffff_ffff, 32'd0, 32'd32768, 32'd19_200_000,
                      $urandom, RATE_RESET, $urandom_range(1, 1000)};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset rate, corners first
        send_corners();
        send_random(PHASE_ITEMS / 2);

        foreach (rate_list[p]) begin
            write_rate(rate_list[p]);
            if (p < 2) begin
                send_corners();
            end
            if (p == 2) begin
                // Hold the output long enough to fill the pipeline and stall the input
                hold_req = 1'b1;
            end
            if (p == 7) begin
                idle_on = 1'b0;
            end
            send_random(PHASE_ITEMS);
        end

        drain_all();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.fails == 0) begin
            $display("[tick_time_scale_converter] OK");
        end else begin
            $display("[tick_time_scale_converter] ERROR");
        end
        $finish;
    end

endmodule
